FILE: sv/adsr_pkg.sv
// Shared types and constants for the ADSR envelope generator.
package adsr_pkg;

  // Request function codes
  localparam logic [1:0] FUNC_TICK        = 2'd0;
  localparam logic [1:0] FUNC_NOTE_ON     = 2'd1;
  localparam logic [1:0] FUNC_NOTE_ON_VEL = 2'd2;
  localparam logic [1:0] FUNC_NOTE_OFF    = 2'd3;

  // Envelope phase codes
  localparam logic [2:0] PH_ATTACK  = 3'd0;
  localparam logic [2:0] PH_DECAY   = 3'd1;
  localparam logic [2:0] PH_SUSTAIN = 3'd2;
  localparam logic [2:0] PH_RELEASE = 3'd3;
  localparam logic [2:0] PH_END     = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_ATTACK  = 2'd0;
  localparam logic [1:0] CFG_DECAY   = 2'd1;
  localparam logic [1:0] CFG_SUSTAIN = 2'd2;
  localparam logic [1:0] CFG_RELEASE = 2'd3;

  localparam logic [7:0] FULL_SCALE = 8'd255;
  localparam logic [8:0] COUNT_MAX  = 9'd511;

  // Command to the shared multiply/divide unit
  typedef struct packed {
    logic       start;
    logic       is_div;
    logic [8:0] opa;    // multiplier, or dividend in [7:0]
    logic [7:0] opb;    // multiplicand, or nonzero divisor
  } iter_req_t;

  // Result from the shared unit, valid while done is high
  typedef struct packed {
    logic        done;
    logic [16:0] result;
  } iter_rsp_t;

endpackage

FILE: sv/adsr_envelope_generator_top.sv
// Top level of the linear ADSR envelope generator.
//
// Request channel: in_valid/in_stall carry func (tick, note on, note on with
// velocity, note off) and velocity. A request is taken when in_valid is high
// and in_stall is low; in_stall stays high while a request is being worked.
// Result channel: out_valid/out_stall carry level, phase_code and is_active,
// exactly one result per request, in order. The result sits in an output
// register, so a new request is taken while the previous result still waits.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while the block is idle.
// Work per request: a tick in attack runs a divide (8 steps) then a
// multiply (9 steps); ticks in decay or release one multiply; note on and
// note off one divide; note on with velocity a multiply then a divide;
// other ticks use no unit. The next request can be taken in the same
// cycle that the previous result comes up.
// All multiplies and divides go through the one shared shift-add/restoring
// unit; one request is in work at a time.
// Reset (rst, synchronous): config back to defaults, envelope in end phase,
// no result pending. A stalled result holds; the block finishes the request
// in work and then waits with in_stall high until the output register frees.
module adsr_envelope_generator_top (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [6:0] velocity,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] level,
  output logic [2:0] phase_code,
  output logic       is_active,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ATK_DIV  = 7'b0000010,  // attack step = 255 / attack_time
    S_TICK_MUL = 7'b0000100,  // count * step for the tick
    S_VEL_MUL  = 7'b0001000,  // sustain * velocity
    S_FALL_DIV = 7'b0010000,  // decay step
    S_REL_DIV  = 7'b0100000,  // release step
    S_FIN      = 7'b1000000   // hand the result to the output register
  } state_t;

  state_t state, state_next;

  // configuration
  logic [7:0] attack_time, decay_time, sustain_level, release_time;

  // envelope state
  logic [2:0] phase_reg;
  logic       running;
  logic [7:0] level_reg;
  logic [8:0] tick_count;
  logic [7:0] peak_level, held_sustain, fall_step, release_start, release_step;

  adsr_pkg::iter_req_t req;
  adsr_pkg::iter_rsp_t rsp;

  logic        in_acc;
  logic        out_free;
  logic        tick_work;
  logic [8:0]  cnt_inc;
  logic [7:0]  atk_div, dec_div, rel_div;
  logic [7:0]  rs_sel;
  logic [7:0]  held_vel;
  logic [7:0]  quot;
  logic [16:0] prod;
  logic        atk_hit, dec_hit, rel_hit;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  // A zero time acts as one
  assign atk_div = (attack_time == 8'd0) ? 8'd1 : attack_time;
  assign dec_div = (decay_time == 8'd0) ? 8'd1 : decay_time;
  assign rel_div = (release_time == 8'd0) ? 8'd1 : release_time;

  assign cnt_inc   = (tick_count == adsr_pkg::COUNT_MAX) ? tick_count : tick_count + 9'd1;
  assign tick_work = running && (phase_reg == adsr_pkg::PH_ATTACK ||
                                 phase_reg == adsr_pkg::PH_DECAY ||
                                 phase_reg == adsr_pkg::PH_RELEASE);
  assign rs_sel    = (phase_reg == adsr_pkg::PH_SUSTAIN) ? held_sustain : level_reg;

  assign prod     = rsp.result;
  assign quot     = rsp.result[7:0];
  assign held_vel = rsp.result[14:7];

  // End-of-segment compares against the fresh product
  assign atk_hit = prod >= {9'd0, peak_level};
  assign dec_hit = ({1'b0, prod} + {10'd0, held_sustain}) >= {10'd0, peak_level};
  assign rel_hit = prod >= {9'd0, release_start};

  // Sequencer and commands to the shared unit
  always_comb begin
    state_next = state;
    req        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          unique case (func)
            adsr_pkg::FUNC_TICK: begin
              if (tick_work) begin
                if (phase_reg == adsr_pkg::PH_ATTACK) begin
                  req.start  = 1'b1;
                  req.is_div = 1'b1;
                  req.opa    = {1'b0, adsr_pkg::FULL_SCALE};
                  req.opb    = atk_div;
                  state_next = S_ATK_DIV;
                end else begin
                  req.start  = 1'b1;
                  req.opa    = cnt_inc;
                  req.opb    = (phase_reg == adsr_pkg::PH_DECAY) ? fall_step : release_step;
                  state_next = S_TICK_MUL;
                end
              end else begin
                state_next = S_FIN;
              end
            end
            adsr_pkg::FUNC_NOTE_ON: begin
              req.start  = 1'b1;
              req.is_div = 1'b1;
              req.opa    = {1'b0, ~sustain_level};  // 255 - sustain
              req.opb    = dec_div;
              state_next = S_FALL_DIV;
            end
            adsr_pkg::FUNC_NOTE_ON_VEL: begin
              req.start  = 1'b1;
              req.opa    = {1'b0, sustain_level};
              req.opb    = {1'b0, velocity};
              state_next = S_VEL_MUL;
            end
            adsr_pkg::FUNC_NOTE_OFF: begin
              req.start  = 1'b1;
              req.is_div = 1'b1;
              req.opa    = {1'b0, rs_sel};
              req.opb    = rel_div;
              state_next = S_REL_DIV;
            end
            default: state_next = S_FIN;
          endcase
        end
      end
      S_ATK_DIV: begin
        if (rsp.done) begin
          req.start  = 1'b1;
          req.opa    = tick_count;
          req.opb    = quot;
          state_next = S_TICK_MUL;
        end
      end
      S_VEL_MUL: begin
        if (rsp.done) begin
          req.start  = 1'b1;
          req.is_div = 1'b1;
          req.opa    = {1'b0, ~held_vel};
          req.opb    = dec_div;
          state_next = S_FALL_DIV;
        end
      end
      S_TICK_MUL, S_FALL_DIV, S_REL_DIV: begin
        if (rsp.done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  adsr_iter u_iter (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      attack_time   <= 8'd1;
      decay_time    <= 8'd1;
      sustain_level <= 8'd0;
      release_time  <= 8'd1;
      phase_reg     <= adsr_pkg::PH_END;
      running       <= 1'b0;
      level_reg     <= 8'd0;
      tick_count    <= 9'd0;
      peak_level    <= adsr_pkg::FULL_SCALE;
      held_sustain  <= 8'd0;
      fall_step     <= 8'd0;
      release_start <= 8'd0;
      release_step  <= 8'd1;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        unique case (cfg_index)
          adsr_pkg::CFG_ATTACK:  attack_time   <= cfg_data;
          adsr_pkg::CFG_DECAY:   decay_time    <= cfg_data;
          adsr_pkg::CFG_SUSTAIN: sustain_level <= cfg_data;
          adsr_pkg::CFG_RELEASE: release_time  <= cfg_data;
          default: ;
        endcase
      end

      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            unique case (func)
              adsr_pkg::FUNC_TICK: begin
                if (running) begin
                  unique case (phase_reg)
                    adsr_pkg::PH_ATTACK, adsr_pkg::PH_DECAY, adsr_pkg::PH_RELEASE: begin
                      tick_count <= cnt_inc;
                    end
                    adsr_pkg::PH_SUSTAIN: begin
                      if (held_sustain == 8'd0) begin
                        phase_reg  <= adsr_pkg::PH_END;
                        running    <= 1'b0;
                        tick_count <= 9'd0;
                        level_reg  <= 8'd0;
                      end else begin
                        level_reg <= held_sustain;
                      end
                    end
                    default: begin
                      running   <= 1'b0;
                      level_reg <= 8'd0;
                    end
                  endcase
                end
              end
              adsr_pkg::FUNC_NOTE_ON: begin
                level_reg    <= 8'd0;
                tick_count   <= 9'd0;
                phase_reg    <= adsr_pkg::PH_ATTACK;
                running      <= 1'b1;
                peak_level   <= adsr_pkg::FULL_SCALE;
                held_sustain <= sustain_level;
              end
              adsr_pkg::FUNC_NOTE_ON_VEL: begin
                level_reg  <= 8'd0;
                tick_count <= 9'd0;
                phase_reg  <= adsr_pkg::PH_ATTACK;
                running    <= 1'b1;
                peak_level <= {velocity, 1'b0};
              end
              adsr_pkg::FUNC_NOTE_OFF: begin
                release_start <= rs_sel;
                tick_count    <= 9'd0;
                phase_reg     <= adsr_pkg::PH_RELEASE;
              end
              default: ;
            endcase
          end
        end
        S_TICK_MUL: begin
          if (rsp.done) begin
            unique case (phase_reg)
              adsr_pkg::PH_ATTACK: begin
                if (atk_hit) begin
                  phase_reg  <= adsr_pkg::PH_DECAY;
                  tick_count <= 9'd0;
                  level_reg  <= peak_level;
                end else begin
                  level_reg <= prod[7:0];
                end
              end
              adsr_pkg::PH_DECAY: begin
                if (dec_hit) begin
                  phase_reg  <= adsr_pkg::PH_SUSTAIN;
                  tick_count <= 9'd0;
                  level_reg  <= held_sustain;
                end else begin
                  level_reg <= peak_level - prod[7:0];
                end
              end
              adsr_pkg::PH_RELEASE: begin
                if (rel_hit) begin
                  phase_reg  <= adsr_pkg::PH_END;
                  running    <= 1'b0;
                  tick_count <= 9'd0;
                  level_reg  <= 8'd0;
                end else begin
                  level_reg <= release_start - prod[7:0];
                end
              end
              default: ;
            endcase
          end
        end
        S_VEL_MUL: begin
          if (rsp.done) begin
            held_sustain <= held_vel;  // (sustain * velocity) >> 7
          end
        end
        S_FALL_DIV: begin
          if (rsp.done) begin
            fall_step <= quot;
          end
        end
        S_REL_DIV: begin
          if (rsp.done) begin
            release_step <= (quot == 8'd0) ? 8'd1 : quot;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      level      <= level_reg;
      phase_code <= phase_reg;
      is_active  <= running;
    end
  end

  // A running envelope is never in the end phase
  a_run_phase: assert property (@(posedge clk) disable iff (rst)
    running |-> (phase_reg != adsr_pkg::PH_END))
    else $error("running envelope in end phase");

  // Release step is never zero
  a_rel_step: assert property (@(posedge clk) disable iff (rst)
    release_step != 8'd0)
    else $error("zero release step");

  // Attack never overshoots the peak
  a_attack: assert property (@(posedge clk) disable iff (rst)
    (running && phase_reg == adsr_pkg::PH_ATTACK) |-> (level_reg <= peak_level))
    else $error("attack level above peak");

  // Decay and sustain never drop below the held sustain level
  a_decay: assert property (@(posedge clk) disable iff (rst)
    (running && (phase_reg == adsr_pkg::PH_DECAY || phase_reg == adsr_pkg::PH_SUSTAIN))
      |-> (level_reg >= held_sustain))
    else $error("level below sustain in decay or sustain");

  // The shared unit only finishes while the sequencer waits for it
  a_unit_done: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_ATK_DIV || state == S_TICK_MUL || state == S_VEL_MUL ||
                  state == S_FALL_DIV || state == S_REL_DIV))
    else $error("unit result with no waiting step");

endmodule

FILE: sv/adsr_iter.sv
// Shared iterative unit: 9x8 shift-add multiply or 8/8 restoring divide on one adder.
module adsr_iter (
  input  logic                 clk,
  input  logic                 rst,
  input  adsr_pkg::iter_req_t  req,
  output adsr_pkg::iter_rsp_t  rsp
);

  localparam logic [3:0] DIV_LAST = 4'd7;
  localparam logic [3:0] MUL_LAST = 4'd8;

  logic        busy;
  logic        done;
  logic        is_div;
  logic [3:0]  cnt;
  logic [16:0] acc;
  logic [8:0]  sh;
  logic [7:0]  b;

  logic [16:0] shifted;
  logic [17:0] addend;
  logic [17:0] sum;
  logic        qbit;
  logic        last;

  // One adder: acc*2 + b when the top multiplier bit is set (multiply) or remainder*2 + next bit - b (divide)
  always_comb begin
    shifted = {acc[15:0], is_div & sh[8]};
    if (is_div) begin
      addend = ~{10'd0, b};
    end else begin
      addend = sh[8] ? {10'd0, b} : 18'd0;
    end
    sum  = {1'b0, shifted} + addend + {17'd0, is_div};
    qbit = ~sum[17];
    last = is_div ? (cnt == DIV_LAST) : (cnt == MUL_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      is_div <= req.is_div;
      acc    <= 17'd0;
      sh     <= req.is_div ? {req.opa[7:0], 1'b0} : req.opa;
      b      <= req.opb;
      cnt    <= 4'd0;
    end else if (busy) begin
      cnt <= cnt + 4'd1;
      if (is_div) begin
        acc <= qbit ? sum[16:0] : shifted;
        sh  <= {sh[7:0], qbit};
      end else begin
        acc <= sum[16:0];
        sh  <= {sh[7:0], 1'b0};
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = is_div ? {9'd0, sh[7:0]} : acc;

endmodule

FILE: tb/adsr_envelope_generator_top_test.sv
// Self-checking testbench for the ADSR envelope generator top level.
`timescale 1ns / 1ps

module adsr_envelope_generator_top_test;

  // No-progress limit: well above the slowest request
  // plus the longest plausible run of sender gaps and receiver stalls.
  localparam int QUIET_LIMIT = 4000;
  // Drain pause at the end.
  localparam int TAIL_CYCLES = 40;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] func = adsr_pkg::FUNC_TICK;
  logic [6:0] velocity = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] level;
  logic [2:0] phase_code;
  logic       is_active;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = adsr_pkg::CFG_ATTACK;
  logic [7:0] cfg_data = '0;

  int send_idle_pct = 0;   // chance per cycle that the sender holds off
  int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  int requests_sent = 0;
  int quiet_cycles = 0;

  typedef struct {
    logic [7:0] level;
    logic [2:0] phase;
    logic       active;
  } env_result_t;

  // Envelope predictor plus the queue of results still owed by the block.
  class envelope_scoreboard;
    bit [7:0]    attack_div, decay_div, sustain_cfg, release_div;
    logic [2:0]  phase;
    bit          running;
    bit [7:0]    env_level;
    bit [8:0]    ticks;
    bit [7:0]    peak, held_level, decay_step, release_from, release_step;
    env_result_t expected_env[$];
    int          errors;

    function new();
      attack_div   = 8'd1;
      decay_div    = 8'd1;
      sustain_cfg  = 8'd0;
      release_div  = 8'd1;
      phase        = adsr_pkg::PH_END;
      running      = 1'b0;
      env_level    = '0;
      ticks        = '0;
      peak         = adsr_pkg::FULL_SCALE;
      held_level   = '0;
      decay_step   = '0;
      release_from = '0;
      release_step = 8'd1;
      errors       = 0;
    endfunction

    // a zero time register divides by one
    function int quot(int n, bit [7:0] d);
      return (d == 0) ? n : n / int'(d);
    endfunction

    function void count_up();
      if (ticks != adsr_pkg::COUNT_MAX) ticks++;
    endfunction

    function void end_envelope();
      phase     = adsr_pkg::PH_END;
      running   = 1'b0;
      ticks     = '0;
      env_level = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        adsr_pkg::CFG_ATTACK:  attack_div  = data;
        adsr_pkg::CFG_DECAY:   decay_div   = data;
        adsr_pkg::CFG_SUSTAIN: sustain_cfg = data;
        default:               release_div = data;
      endcase
    endfunction

    function void take_request(logic [1:0] f, logic [6:0] v);
      int          lv;
      bit [7:0]    sus;
      env_result_t r;
      case (f)
        adsr_pkg::FUNC_TICK: begin
          if (running) begin
            case (phase)
              adsr_pkg::PH_ATTACK: begin
                count_up();
                lv = int'(ticks) * quot(int'(adsr_pkg::FULL_SCALE), attack_div);
                if (lv >= int'(peak)) begin
                  phase = adsr_pkg::PH_DECAY;
                  ticks = '0;
                  lv    = int'(peak);
                end
                env_level = lv[7:0];
              end
              adsr_pkg::PH_DECAY: begin
                count_up();
                lv = int'(peak) - int'(ticks) * int'(decay_step);
                if (lv <= int'(held_level)) begin
                  phase = adsr_pkg::PH_SUSTAIN;
                  ticks = '0;
                  lv    = int'(held_level);
                end
                env_level = lv[7:0];
              end
              adsr_pkg::PH_SUSTAIN: begin
                env_level = held_level;
                if (held_level == 0) end_envelope();
              end
              adsr_pkg::PH_RELEASE: begin
                count_up();
                lv = int'(release_from) - int'(ticks) * int'(release_step);
                if (lv <= 0) end_envelope();
                else env_level = lv[7:0];
              end
              default: begin
                running   = 1'b0;
                env_level = '0;
              end
            endcase
          end
        end
        adsr_pkg::FUNC_NOTE_ON, adsr_pkg::FUNC_NOTE_ON_VEL: begin
          if (f == adsr_pkg::FUNC_NOTE_ON) begin
            peak = adsr_pkg::FULL_SCALE;
            sus  = sustain_cfg;
          end else begin
            peak = {v, 1'b0};
            sus  = 8'((int'(sustain_cfg) * int'(v)) >> 7);
          end
          env_level  = '0;
          ticks      = '0;
          phase      = adsr_pkg::PH_ATTACK;
          running    = 1'b1;
          held_level = sus;
          decay_step = 8'(quot(int'(adsr_pkg::FULL_SCALE) - int'(sus), decay_div));
        end
        default: begin
          // note off: running flag is left alone
          release_from = (phase == adsr_pkg::PH_SUSTAIN) ? held_level : env_level;
          ticks        = '0;
          phase        = adsr_pkg::PH_RELEASE;
          release_step = 8'(quot(int'(release_from), release_div));
          if (release_step == 0) release_step = 8'd1;
        end
      endcase
      r.level  = env_level;
      r.phase  = phase;
      r.active = running;
      expected_env.push_back(r);
    endfunction

    function void check_result(logic [7:0] lv, logic [2:0] ph, logic act);
      env_result_t e;
      if (expected_env.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: level %0d phase %0d active %0b",
                 $time, lv, ph, act);
        return;
      end
      e = expected_env.pop_front();
      if (lv !== e.level) begin
        errors++;
        $display("%0t: level mismatch: expected %0d, actual %0d", $time, e.level, lv);
      end
      if (ph !== e.phase) begin
        errors++;
        $display("%0t: phase mismatch: expected %0d, actual %0d", $time, e.phase, ph);
      end
      if (act !== e.active) begin
        errors++;
        $display("%0t: is_active mismatch: expected %0b, actual %0b",
                 $time, e.active, act);
      end
    endfunction
  endclass

  envelope_scoreboard sb;

  adsr_envelope_generator_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .velocity   (velocity),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .level      (level),
    .phase_code (phase_code),
    .is_active  (is_active),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver back-pressure, redrawn every cycle at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: every handshake is seen at the rising edge. Config writes
  // update the predictor, accepted requests queue an expectation, accepted
  // results are checked. Also the no-progress watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      quiet_cycles++;
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        quiet_cycles = 0;
      end
      if (in_valid && !in_stall) begin
        sb.take_request(func, velocity);
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        sb.check_result(level, phase_code, is_active);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("adsr_envelope_generator_top_test NOT OK");
        $finish;
      end
    end
  end

  // One request: optional sender gap (payload scrambled while idle), then
  // hold valid until the block takes it. Valid is left high afterwards for
  // back-to-back requests.
  task automatic send(logic [1:0] f, logic [6:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      func     <= 2'($urandom_range(3));
      velocity <= 7'($urandom_range(127));
    end
    @(negedge clk);
    in_valid <= 1'b1;
    func     <= f;
    velocity <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    requests_sent++;
  endtask

  // Drop valid and wait for every owed result; the block is then idle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_env.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] atk, logic [7:0] dec, logic [7:0] sus,
                            logic [7:0] rel);
    write_cfg(adsr_pkg::CFG_ATTACK, atk);
    write_cfg(adsr_pkg::CFG_DECAY, dec);
    write_cfg(adsr_pkg::CFG_SUSTAIN, sus);
    write_cfg(adsr_pkg::CFG_RELEASE, rel);
  endtask

  // Mostly short times so envelopes finish within a sequence; sometimes
  // full-range values, sometimes only the extremes (zero time included).
  task automatic random_config();
    logic [7:0] v[4];
    int         mode;
    mode = $urandom_range(7);
    foreach (v[i]) begin
      case (mode)
        0: begin
          case ($urandom_range(2))
            0: v[i] = 8'd0;
            1: v[i] = 8'd1;
            default: v[i] = 8'd255;
          endcase
        end
        1: v[i] = 8'($urandom_range(255));
        default: v[i] = 8'($urandom_range(6));
      endcase
    end
    if (mode > 1) v[2] = 8'($urandom_range(255));  // sustain is a level
    set_config(v[0], v[1], v[2], v[3]);
  endtask

  // One idling phase: mostly note on / ticks / note off / ticks sequences
  // with random lengths, some random noise requests, new config now and then.
  task automatic run_phase(int idle_pct, int stall_pct, int n_req);
    int first;
    int cfg_mark;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first          = requests_sent;
    cfg_mark       = requests_sent - 1000;
    while (requests_sent - first < n_req) begin
      if (requests_sent - cfg_mark >= 60) begin
        drain();
        random_config();
        cfg_mark = requests_sent;
      end
      if ($urandom_range(99) < 85) begin
        send($urandom_range(1) ? adsr_pkg::FUNC_NOTE_ON : adsr_pkg::FUNC_NOTE_ON_VEL,
             7'($urandom_range(127)));
        repeat ($urandom_range(40)) send(adsr_pkg::FUNC_TICK, 7'($urandom_range(127)));
        if ($urandom_range(99) < 80) begin
          send(adsr_pkg::FUNC_NOTE_OFF, 7'($urandom_range(127)));
          repeat ($urandom_range(40)) send(adsr_pkg::FUNC_TICK, 7'($urandom_range(127)));
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send(2'($urandom_range(3)), 7'($urandom_range(127)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset config: tick and note off with nothing running,
    // a full plain envelope, velocity 127 cut short, velocity zero.
    send(adsr_pkg::FUNC_TICK, 7'd0);
    send(adsr_pkg::FUNC_NOTE_OFF, 7'd127);
    send(adsr_pkg::FUNC_TICK, 7'd0);
    send(adsr_pkg::FUNC_NOTE_ON, 7'd0);
    send(adsr_pkg::FUNC_TICK, 7'd0);
    send(adsr_pkg::FUNC_TICK, 7'd0);
    send(adsr_pkg::FUNC_TICK, 7'd0);
    send(adsr_pkg::FUNC_NOTE_ON_VEL, 7'd127);
    send(adsr_pkg::FUNC_TICK, 7'd0);
    send(adsr_pkg::FUNC_NOTE_OFF, 7'd0);
    send(adsr_pkg::FUNC_TICK, 7'd0);
    send(adsr_pkg::FUNC_NOTE_ON_VEL, 7'd0);
    send(adsr_pkg::FUNC_TICK, 7'd0);
    send(adsr_pkg::FUNC_TICK, 7'd0);
    send(adsr_pkg::FUNC_TICK, 7'd0);

    // All registers at max: slow attack, decay step rounds to zero,
    // release step clamps to one.
    drain();
    set_config(8'd255, 8'd255, 8'd255, 8'd255);
    send(adsr_pkg::FUNC_NOTE_ON_VEL, 7'd127);
    send(adsr_pkg::FUNC_TICK, 7'd127);
    send(adsr_pkg::FUNC_TICK, 7'd127);
    send(adsr_pkg::FUNC_NOTE_OFF, 7'd127);
    send(adsr_pkg::FUNC_TICK, 7'd127);
    send(adsr_pkg::FUNC_TICK, 7'd127);

    // Zero time registers act as one; note off taken from sustain.
    drain();
    set_config(8'd0, 8'd0, 8'd128, 8'd0);
    send(adsr_pkg::FUNC_NOTE_ON, 7'd0);
    send(adsr_pkg::FUNC_TICK, 7'd0);
    send(adsr_pkg::FUNC_TICK, 7'd0);
    send(adsr_pkg::FUNC_TICK, 7'd0);
    send(adsr_pkg::FUNC_NOTE_OFF, 7'd0);
    send(adsr_pkg::FUNC_TICK, 7'd0);

    // Random part over the idling phases.
    run_phase(0, 0, 400);
    run_phase(76, 0, 400);
    run_phase(0, 76, 400);
    run_phase(18, 18, 400);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_env.size() == 0) begin
      $display("adsr_envelope_generator_top_test OK");
    end else begin
      $display("adsr_envelope_generator_top_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/adsr_pkg.sv
sv/adsr_iter.sv
sv/adsr_envelope_generator_top.sv
tb/adsr_envelope_generator_top_test.sv
